// ----- rtl/core/dtw_pkg.sv -----
// Shared codes and control bundles for the sequence distance block.
`default_nettype none

package dtw_pkg;

    // Item function codes
    localparam logic FUNC_STORE   = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    // Sequence select codes
    localparam logic SEQ_A = 1'b0;
    localparam logic SEQ_B = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 2'd2;

    // Reset value of the dimension count before clamping
    localparam int DIMS_RESET = 39;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic store_en;   // write one coefficient from the input transfer
        logic rd_en;      // read one coefficient pair at (i, k) and (j, k)
        logic cell_start; // clear the distance sum and read the saved cost of column j
        logic do_add;     // form up, left and doubled-distance candidates
        logic do_diag;    // form the diagonal candidate
        logic do_pick;    // take the minimum and write the cell cost
        logic sat_clr;    // clear the clip flag at compute start
        logic load_out;   // load the result register
    } cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic dist_busy;  // coefficient pipeline still holds terms
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/dtw_ctrl.sv -----
// Sequencer: configuration registers, grid counters and the cell state machine.
`default_nettype none

module dtw_ctrl #(
    parameter int MAX_FRAMES = 128,
    parameter int MAX_DIMS   = 64,
    localparam int FAW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    localparam int DW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int LEN_W  = $clog2(MAX_FRAMES + 1),
    localparam int DIMS_W = $clog2(MAX_DIMS + 1),
    localparam int CFG_W  = (LEN_W > DIMS_W) ? LEN_W : DIMS_W
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              func,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    input  wire logic                              cfg_we,
    input  wire logic [dtw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]                  cfg_data,
    output dtw_pkg::cmd_t                          cmd,
    input  wire dtw_pkg::status_t                  status,
    output logic [FAW-1:0]                         i_idx,
    output logic [FAW-1:0]                         j_idx,
    output logic [DW-1:0]                          k_idx
);

    localparam int DIMS_INIT = (dtw_pkg::DIMS_RESET > MAX_DIMS) ? MAX_DIMS
                                                                : dtw_pkg::DIMS_RESET;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIST   = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_ADD    = 3'd3;
    localparam logic [2:0] S_DIAG   = 3'd4;
    localparam logic [2:0] S_PICK   = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [LEN_W-1:0]  len_a_reg, len_b_reg;
    logic [DIMS_W-1:0] dims_reg;
    logic [FAW-1:0]    i_reg, i_next;
    logic [FAW-1:0]    j_reg, j_next;
    logic [DW-1:0]     k_reg, k_next;
    logic              out_valid_reg, out_valid_next;

    logic [LEN_W-1:0]  cfg_len;
    logic [DIMS_W-1:0] cfg_dims;
    logic [LEN_W-1:0]  len_clamped;
    logic [DIMS_W-1:0] dims_clamped;
    logic              accept;
    logic              out_free;
    logic              last_k, last_i, last_j;

    assign cfg_len  = cfg_data[LEN_W-1:0];
    assign cfg_dims = cfg_data[DIMS_W-1:0];

    // Clamp lengths and dimension count into their working range
    always_comb
    begin
        priority if (cfg_len == '0)
            len_clamped = LEN_W'(1);
        else if (cfg_len > LEN_W'(MAX_FRAMES))
            len_clamped = LEN_W'(MAX_FRAMES);
        else
            len_clamped = cfg_len;

        priority if (cfg_dims == '0)
            dims_clamped = DIMS_W'(1);
        else if (cfg_dims > DIMS_W'(MAX_DIMS))
            dims_clamped = DIMS_W'(MAX_DIMS);
        else
            dims_clamped = cfg_dims;
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= LEN_W'(1);
            len_b_reg <= LEN_W'(1);
            dims_reg  <= DIMS_W'(DIMS_INIT);
        end
        else if (cfg_we)
        begin
            if (cfg_index == dtw_pkg::CFG_LEN_A)
                len_a_reg <= len_clamped;
            if (cfg_index == dtw_pkg::CFG_LEN_B)
                len_b_reg <= len_clamped;
            if (cfg_index == dtw_pkg::CFG_DIMS)
                dims_reg <= dims_clamped;
        end
    end

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign last_k   = ((DIMS_W + 1)'(k_reg) + (DIMS_W + 1)'(1)) == (DIMS_W + 1)'(dims_reg);
    assign last_i   = ((LEN_W + 1)'(i_reg) + (LEN_W + 1)'(1)) == (LEN_W + 1)'(len_a_reg);
    assign last_j   = ((LEN_W + 1)'(j_reg) + (LEN_W + 1)'(1)) == (LEN_W + 1)'(len_b_reg);

    // Step through the grid one cell at a time, one coefficient per cycle while reading a cell
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && func == dtw_pkg::FUNC_STORE)
                    cmd.store_en = 1'b1;
                if (accept && func == dtw_pkg::FUNC_COMPUTE)
                begin
                    cmd.sat_clr = 1'b1;
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    state_next  = S_DIST;
                end
            end
            S_DIST:
            begin
                cmd.rd_en      = 1'b1;
                cmd.cell_start = (k_reg == '0);
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = S_WAIT;
                end
                else
                    k_next = k_reg + DW'(1);
            end
            S_WAIT:
            begin
                if (!status.dist_busy)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.do_add = 1'b1;
                state_next = S_DIAG;
            end
            S_DIAG:
            begin
                cmd.do_diag = 1'b1;
                state_next  = S_PICK;
            end
            S_PICK:
            begin
                cmd.do_pick = 1'b1;
                if (!last_j)
                begin
                    j_next     = j_reg + FAW'(1);
                    state_next = S_DIST;
                end
                else if (!last_i)
                begin
                    j_next     = '0;
                    i_next     = i_reg + FAW'(1);
                    state_next = S_DIST;
                end
                else
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign i_idx     = i_reg;
    assign j_idx     = j_reg;
    assign k_idx     = k_reg;

    // The result register is only loaded when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a waiting result");

    // A compute transfer starts the first cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == dtw_pkg::FUNC_COMPUTE) |=> (state_reg == S_DIST && k_reg == '0))
        else $error("compute did not start the grid");

    // Grid counters stay inside the configured lengths
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIST) |->
            ((LEN_W + 1)'(i_reg) < (LEN_W + 1)'(len_a_reg)
             && (LEN_W + 1)'(j_reg) < (LEN_W + 1)'(len_b_reg)))
        else $error("grid counter beyond configured length");

    // A result only appears after the last cell
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FINISH))
        else $error("result raised outside the finish step");

    // The cell arithmetic never starts while distance terms are in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_add |-> !status.dist_busy)
        else $error("cell update with distance pipeline busy");

endmodule

`default_nettype wire

// ----- rtl/core/dtw_dpath.sv -----
// Datapath: coefficient stores, distance pipeline, saved cost row and cell update.
`default_nettype none

module dtw_dpath #(
    parameter int MAX_FRAMES = 128,
    parameter int MAX_DIMS   = 64,
    parameter int COEF_WIDTH = 16,
    parameter int COST_WIDTH = 48,
    localparam int FAW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dtw_pkg::cmd_t                 cmd,
    output dtw_pkg::status_t                   status,
    input  wire logic [FAW-1:0]                i_idx,
    input  wire logic [FAW-1:0]                j_idx,
    input  wire logic [DW-1:0]                 k_idx,
    input  wire logic                          seq_select,
    input  wire logic [FAW-1:0]                frame_index,
    input  wire logic [DW-1:0]                 coef_index,
    input  wire logic signed [COEF_WIDTH-1:0]  coef_value,
    output logic [COST_WIDTH-1:0]              total_cost,
    output logic                               saturated
);

    localparam int STORE_DEPTH = MAX_FRAMES * (1 << DW);
    localparam int DIST_W      = COEF_WIDTH + 1 + $clog2(MAX_DIMS);
    localparam int SW          = (COST_WIDTH > DIST_W) ? COST_WIDTH : DIST_W;
    localparam logic [SW:0] COST_MAX_X = (SW + 1)'({COST_WIDTH{1'b1}});

    // Add with the first operand clipped to the cost ceiling; never overflows SW+1 bits
    function automatic logic [SW:0] sat_sum(input logic [SW:0] a, input logic [SW:0] b);
        logic [SW:0] ac;
        ac = (a > COST_MAX_X) ? COST_MAX_X : a;
        return ac + b;
    endfunction

    logic signed [COEF_WIDTH-1:0] mem_a [0:STORE_DEPTH-1];
    logic signed [COEF_WIDTH-1:0] mem_b [0:STORE_DEPTH-1];
    logic [COST_WIDTH-1:0]        row_mem [0:MAX_FRAMES-1];

    logic signed [COEF_WIDTH-1:0] a_q_reg, b_q_reg;
    logic [COEF_WIDTH:0]          abs_reg;
    logic [DIST_W-1:0]            acc_reg;
    logic                         rd_v_reg, abs_v_reg;
    logic [COST_WIDTH-1:0]        row_q_reg;
    logic [COST_WIDTH-1:0]        left_reg, diag_reg;
    logic [COST_WIDTH-1:0]        vu_reg, vl_reg, vd_reg, d2_reg;
    logic                         cu_reg, cl_reg, c2_reg, cd_reg;
    logic                         sat_reg;
    logic [COST_WIDTH-1:0]        total_cost_reg;
    logic                         saturated_reg;

    logic                         frame_ok, coef_ok;
    logic [FAW+DW-1:0]            st_addr;
    logic signed [COEF_WIDTH:0]   diff;
    logic [SW:0]                  dd_x, up_x, left_x, s_d2, s_u, s_l, s_d;
    logic                         first_row, first_col;
    logic [COST_WIDTH-1:0]        m_min, cell_val;
    logic                         clip_all, clip_now;

    assign frame_ok = (FAW + 1)'(frame_index) < (FAW + 1)'(MAX_FRAMES);
    assign coef_ok  = (DW + 1)'(coef_index) < (DW + 1)'(MAX_DIMS);
    assign st_addr  = {frame_index, coef_index};

    // Coefficient stores: one write from the input, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.store_en && frame_ok && coef_ok && seq_select == dtw_pkg::SEQ_A)
            mem_a[st_addr] <= coef_value;
        if (cmd.rd_en)
            a_q_reg <= mem_a[{i_idx, k_idx}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_en && frame_ok && coef_ok && seq_select == dtw_pkg::SEQ_B)
            mem_b[st_addr] <= coef_value;
        if (cmd.rd_en)
            b_q_reg <= mem_b[{j_idx, k_idx}];
    end

    // Saved cost row: read the up cost at cell start, write the cell cost at pick
    always_ff @(posedge clk)
    begin
        if (cmd.do_pick)
            row_mem[j_idx] <= cell_val;
        if (cmd.cell_start)
            row_q_reg <= row_mem[j_idx];
    end

    // Absolute difference, then accumulate over the dimensions
    assign diff = (COEF_WIDTH + 1)'(a_q_reg) - (COEF_WIDTH + 1)'(b_q_reg);

    always_ff @(posedge clk)
    begin
        abs_reg <= diff[COEF_WIDTH] ? (COEF_WIDTH + 1)'(-diff) : (COEF_WIDTH + 1)'(diff);
        if (cmd.cell_start)
            acc_reg <= '0;
        else if (abs_v_reg)
            acc_reg <= acc_reg + DIST_W'(abs_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg  <= 1'b0;
            abs_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= cmd.rd_en;
            abs_v_reg <= rd_v_reg;
        end
    end

    assign status.dist_busy = rd_v_reg || abs_v_reg;

    // Candidate sums
    assign first_row = (i_idx == '0);
    assign first_col = (j_idx == '0);
    assign dd_x      = (SW + 1)'(acc_reg);
    assign up_x      = (SW + 1)'(row_q_reg);
    assign left_x    = first_col ? '0 : (SW + 1)'(left_reg);
    assign s_d2      = sat_sum(dd_x, dd_x);
    assign s_u       = sat_sum(up_x, dd_x);
    assign s_l       = sat_sum(left_x, dd_x);
    assign s_d       = sat_sum((SW + 1)'(diag_reg), (SW + 1)'(d2_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.do_add)
        begin
            c2_reg <= s_d2 > COST_MAX_X;
            d2_reg <= (s_d2 > COST_MAX_X) ? COST_MAX_X[COST_WIDTH-1:0] : s_d2[COST_WIDTH-1:0];
            cu_reg <= s_u > COST_MAX_X;
            vu_reg <= (s_u > COST_MAX_X) ? COST_MAX_X[COST_WIDTH-1:0] : s_u[COST_WIDTH-1:0];
            cl_reg <= s_l > COST_MAX_X;
            vl_reg <= (s_l > COST_MAX_X) ? COST_MAX_X[COST_WIDTH-1:0] : s_l[COST_WIDTH-1:0];
        end
        if (cmd.do_diag)
        begin
            cd_reg <= (s_d > COST_MAX_X) || c2_reg;
            vd_reg <= (s_d > COST_MAX_X) ? COST_MAX_X[COST_WIDTH-1:0] : s_d[COST_WIDTH-1:0];
        end
    end

    // Left on row 0, up on column 0, else cheapest; clip only if all winners clipped
    always_comb
    begin
        m_min = vu_reg;
        if (vd_reg < m_min)
            m_min = vd_reg;
        if (vl_reg < m_min)
            m_min = vl_reg;
        clip_all = (vu_reg != m_min || cu_reg)
                && (vd_reg != m_min || cd_reg)
                && (vl_reg != m_min || cl_reg);

        priority if (first_row)
        begin
            cell_val = vl_reg;
            clip_now = cl_reg;
        end
        else if (first_col)
        begin
            cell_val = vu_reg;
            clip_now = cu_reg;
        end
        else
        begin
            cell_val = m_min;
            clip_now = clip_all;
        end
    end

    // Hold the left and diagonal neighbours for the next cell
    always_ff @(posedge clk)
    begin
        if (cmd.do_pick)
        begin
            left_reg <= cell_val;
            diag_reg <= row_q_reg;
        end
        if (cmd.load_out)
        begin
            total_cost_reg <= left_reg;
            saturated_reg  <= sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sat_reg <= 1'b0;
        else if (cmd.sat_clr)
            sat_reg <= 1'b0;
        else if (cmd.do_pick && clip_now)
            sat_reg <= 1'b1;
    end

    assign total_cost = total_cost_reg;
    assign saturated  = saturated_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dtw_sequence_distance.sv -----
// Top level: sequence distance block joining the sequencer and the datapath.
// Store item: written when taken, no result; one store per cycle while idle.
// Compute item: the grid is walked cell by cell; each cell distance is read through the
//   single read port of each coefficient store (one coefficient pair per cycle while a cell is read).
// Only one compute runs at a time; input stalls until its result is in the output register.
// Reset clears control; len_a=1, len_b=1, dims_in_use=39 (max MAX_DIMS); stores not cleared.
`default_nettype none

module dtw_sequence_distance #(
    parameter int MAX_FRAMES = 128,
    parameter int MAX_DIMS   = 64,
    parameter int COEF_WIDTH = 16,
    parameter int COST_WIDTH = 48,
    localparam int FAW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    localparam int DW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int LEN_W  = $clog2(MAX_FRAMES + 1),
    localparam int DIMS_W = $clog2(MAX_DIMS + 1),
    localparam int CFG_W  = (LEN_W > DIMS_W) ? LEN_W : DIMS_W
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             func,
    input  wire logic                             seq_select,
    input  wire logic [FAW-1:0]                   frame_index,
    input  wire logic [DW-1:0]                    coef_index,
    input  wire logic signed [COEF_WIDTH-1:0]     coef_value,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [COST_WIDTH-1:0]                 total_cost,
    output logic                                  saturated,
    input  wire logic                             cfg_we,
    input  wire logic [dtw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]                 cfg_data
);

    dtw_pkg::cmd_t    cmd;
    dtw_pkg::status_t status;
    logic [FAW-1:0]   i_idx, j_idx;
    logic [DW-1:0]    k_idx;

    // Sequencer
    dtw_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_DIMS   (MAX_DIMS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .i_idx     (i_idx),
        .j_idx     (j_idx),
        .k_idx     (k_idx)
    );

    // Datapath
    dtw_dpath #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_DIMS   (MAX_DIMS),
        .COEF_WIDTH (COEF_WIDTH),
        .COST_WIDTH (COST_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .i_idx       (i_idx),
        .j_idx       (j_idx),
        .k_idx       (k_idx),
        .seq_select  (seq_select),
        .frame_index (frame_index),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .total_cost  (total_cost),
        .saturated   (saturated)
    );

endmodule

`default_nettype wire
